### rtl/core/pel_pkg.sv
package pel_pkg;

  localparam int unsigned DefCapacity = 64;
  localparam int unsigned StartW      = 32;
  localparam int unsigned HandleW     = 16;

  typedef enum logic [1:0] {
    OpInsert  = 2'd0,
    OpDelete  = 2'd1,
    OpSearch  = 2'd2,
    OpSetText = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    StatOk       = 2'd0,
    StatOutOfBnd = 2'd1,
    StatNotFound = 2'd2,
    StatFull     = 2'd3
  } status_e;

  typedef struct packed {
    logic               occ;
    logic [StartW-1:0]  start;
    logic [HandleW-1:0] type_h;
    logic [HandleW-1:0] text_h;
  } cell_data_t;

  typedef struct packed {
    op_e                op;
    logic               apply;
    logic               search;
    logic [StartW-1:0]  key;
    logic [HandleW-1:0] type_h;
    logic [HandleW-1:0] text_h;
  } cell_cmd_t;

endpackage

### rtl/core/pel_cell.sv
module pel_cell
  import pel_pkg::*;
#(
  parameter int unsigned Idx   = 0,
  parameter int unsigned SlotW = 6
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cell_cmd_t        cmd_i,
  input  logic [SlotW-1:0] slot_i,
  input  cell_data_t       left_i,
  input  cell_data_t       right_i,
  output cell_data_t       data_o,
  output logic             match_o
);

  logic               occ_q, occ_d;
  logic [StartW-1:0]  start_q, start_d;
  logic [HandleW-1:0] type_q, type_d;
  logic [HandleW-1:0] text_q, text_d;
  logic               match_q;
  logic               here, past;

  assign here = (slot_i == SlotW'(Idx));
  assign past = (slot_i < SlotW'(Idx));

  always_comb begin
    occ_d   = occ_q;
    start_d = start_q;
    type_d  = type_q;
    text_d  = text_q;
    if (cmd_i.apply) begin
      case (cmd_i.op)
        OpInsert: begin
          if (here) begin
            occ_d   = 1'b1;
            start_d = cmd_i.key;
            type_d  = cmd_i.type_h;
            text_d  = '0;
          end else if (past) begin
            occ_d   = left_i.occ;
            start_d = left_i.start;
            type_d  = left_i.type_h;
            text_d  = left_i.text_h;
          end
        end
        OpDelete: begin
          if (here || past) begin
            occ_d   = right_i.occ;
            start_d = right_i.start;
            type_d  = right_i.type_h;
            text_d  = right_i.text_h;
          end
        end
        OpSetText: begin
          if (here) begin
            text_d = cmd_i.text_h;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q   <= 1'b0;
      match_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
      if (cmd_i.search) begin
        match_q <= occ_q && (start_q == cmd_i.key);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    start_q <= start_d;
    type_q  <= type_d;
    text_q  <= text_d;
  end

  assign data_o  = '{occ: occ_q, start: start_q, type_h: type_q, text_h: text_q};
  assign match_o = match_q;

endmodule

### rtl/core/pel_first_match.sv
module pel_first_match
  import pel_pkg::*;
#(
  parameter int unsigned Capacity = DefCapacity,
  parameter int unsigned CntW     = $clog2(DefCapacity + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  logic [Capacity-1:0] match_i,
  output logic [CntW-1:0]     found_o
);

  logic [Capacity-1:0] onehot_q, onehot_d;

  // The lowest set bit is isolated by a single two's-complement add.
  assign onehot_d = match_i & (~match_i + Capacity'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      onehot_q <= '0;
    end else if (load_i) begin
      onehot_q <= onehot_d;
    end
  end

  always_comb begin
    found_o = '0;
    for (int unsigned i = 0; i < Capacity; i++) begin
      if (onehot_q[i]) begin
        found_o = found_o | CntW'(i + 1);
      end
    end
  end

  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot0(onehot_q))
    else $error("First-match vector holds more than one bit.");

endmodule

### rtl/core/positional_entry_list_top.sv
// Channel | Direction | Handshake             | Payload
// in      | input     | in_valid_i/in_ready_o | op_i, position_i, start_time_i, type_handle_i,
//         |           |                       | text_handle_i
// out     | output    | out_valid_o/out_ready_i | status_o, found_position_o, entry_count_o
//
// For insert, delete and set-text, any cell row update happens at the input transfer, and the
// result is then loaded into the output register once that register is free.
// Search proceeds through cell compare, lowest-match isolation, position encode and output load.
// The input is taken one request at a time; a finished result may wait in the output register.
// Reset empties the list at once; the entry stores themselves are not cleared.
module positional_entry_list_top
  import pel_pkg::*;
#(
  parameter int unsigned Capacity = DefCapacity,
  localparam int unsigned PosW  = $clog2(Capacity + 2),
  localparam int unsigned CntW  = $clog2(Capacity + 1),
  localparam int unsigned SlotW = $clog2(Capacity)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [1:0]                op_i,
  input  logic [PosW-1:0]           position_i,
  input  logic signed [StartW-1:0]  start_time_i,
  input  logic [HandleW-1:0]        type_handle_i,
  input  logic [HandleW-1:0]        text_handle_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [1:0]                status_o,
  output logic [CntW-1:0]           found_position_o,
  output logic [CntW-1:0]           entry_count_o
);

  typedef enum logic [1:0] {
    StIdle,
    StSrchA,
    StSrchB,
    StDone
  } state_e;

  state_e             state_q;
  logic [CntW-1:0]    count_q, count_d;
  status_e            res_status_q, acc_status;
  logic [CntW-1:0]    res_found_q;
  logic               out_valid_q;
  status_e            out_status_q;
  logic [CntW-1:0]    out_found_q, out_count_q;
  logic               out_load;

  logic               in_acc;
  op_e                op;
  logic [PosW:0]      pos_ext, cnt_ext;
  logic               ins_oob, rng_oob, full;
  logic               apply;
  logic [SlotW-1:0]   slot;
  cell_cmd_t          cmd;
  cell_data_t         cell_data [Capacity];
  cell_data_t         left_w    [Capacity];
  cell_data_t         right_w   [Capacity];
  logic [Capacity-1:0] match;
  logic [CntW-1:0]    found;

  assign in_ready_o = (state_q == StIdle);
  assign in_acc     = in_valid_i && in_ready_o;
  assign op         = op_e'(op_i);
  assign out_load   = (state_q == StDone) && (!out_valid_q || out_ready_i);

  assign pos_ext = (PosW + 1)'(position_i);
  assign cnt_ext = (PosW + 1)'(count_q);
  assign ins_oob = (position_i == '0) || (pos_ext > cnt_ext + (PosW + 1)'(1));
  assign rng_oob = (position_i == '0) || (pos_ext > cnt_ext);
  assign full    = (count_q == CntW'(Capacity));
  assign slot    = SlotW'(position_i - PosW'(1));

  always_comb begin
    acc_status = StatOk;
    apply      = 1'b0;
    count_d    = count_q;
    case (op)
      OpInsert: begin
        if (ins_oob) begin
          acc_status = StatOutOfBnd;
        end else if (full) begin
          acc_status = StatFull;
        end else begin
          apply   = in_acc;
          count_d = count_q + CntW'(1);
        end
      end
      OpDelete: begin
        if (rng_oob) begin
          acc_status = StatOutOfBnd;
        end else begin
          apply   = in_acc;
          count_d = count_q - CntW'(1);
        end
      end
      OpSetText: begin
        if (rng_oob) begin
          acc_status = StatOutOfBnd;
        end else begin
          apply = in_acc;
        end
      end
      default: begin
      end
    endcase
  end

  assign cmd = '{op: op, apply: apply, search: in_acc && (op == OpSearch),
                 key: start_time_i, type_h: type_handle_i, text_h: text_handle_i};

  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign left_w[i] = '0;
    end else begin : g_left
      assign left_w[i] = cell_data[i-1];
    end
    if (i == Capacity - 1) begin : g_last
      assign right_w[i] = '0;
    end else begin : g_right
      assign right_w[i] = cell_data[i+1];
    end

    pel_cell #(
      .Idx   (i),
      .SlotW (SlotW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd),
      .slot_i  (slot),
      .left_i  (left_w[i]),
      .right_i (right_w[i]),
      .data_o  (cell_data[i]),
      .match_o (match[i])
    );
  end

  pel_first_match #(
    .Capacity (Capacity),
    .CntW     (CntW)
  ) u_first_match (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (state_q == StSrchA),
    .match_i (match),
    .found_o (found)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      count_q      <= '0;
      res_status_q <= StatOk;
      res_found_q  <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= StatOk;
      out_found_q  <= '0;
      out_count_q  <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (in_acc) begin
            count_q      <= count_d;
            res_status_q <= acc_status;
            res_found_q  <= '0;
            state_q      <= (op == OpSearch) ? StSrchA : StDone;
          end
        end
        StSrchA: begin
          state_q <= StSrchB;
        end
        StSrchB: begin
          res_found_q  <= found;
          res_status_q <= (found != '0) ? StatOk : StatNotFound;
          state_q      <= StDone;
        end
        StDone: begin
          if (out_load) begin
            out_status_q <= res_status_q;
            out_found_q  <= res_found_q;
            out_count_q  <= count_q;
            state_q      <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign found_position_o = out_found_q;
  assign entry_count_o    = out_count_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Capacity))
    else $error("Entry count exceeds the capacity.");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (apply && op == OpInsert) |=> count_q == CntW'($past(count_q) + CntW'(1)))
    else $error("Accepted insert did not grow the list by one.");

  a_found_in_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> found_position_o <= entry_count_o)
    else $error("Search result lies beyond the end of the list.");

  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && found_position_o != '0) |-> status_o == StatOk)
    else $error("Non-zero position reported with a failing status.");

endmodule
